// File: design/dqmt_pkg.sv
// Types and codes shared by the dedup queue cells and the top level.
// No dependencies.
package dqmt_pkg;

  // command codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // input word
  typedef struct packed {
    logic        cmd;
    logic [31:0] item_in;
  } in_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic        is_empty;
    logic [4:0]  fill_count;
  } out_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic        en;       // an accepted word changes the queue this cycle
    logic        put;
    logic        get;
    logic        any_hit;  // some occupied cell matches the item
    logic [31:0] item;
  } cell_ctrl_t;

endpackage

// File: design/dqmt_cell.sv
// One storage cell of the dedup queue: holds a slot, compares it with the
// new item, and shifts toward the head. Depends on dqmt_pkg.
module dqmt_cell
  import dqmt_pkg::*;
(
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic        occ,        // this cell holds a queued item
  input  logic        sel_last,   // this cell is the current tail
  input  logic        sel_free,   // this cell is the first free slot
  input  logic [31:0] slot_next,  // value of the neighbor toward the tail
  input  logic        hit_in,     // a match at some cell nearer the head
  output logic        hit_out,
  output logic [31:0] slot_out
);

  logic [31:0] slot_r;
  logic [31:0] slot_nxt;
  logic        hit_le;
  logic        shift;
  logic        load;

  // match chain: hit_le is set from the matching cell onward
  assign hit_le  = hit_in | (occ && (slot_r == ctrl.item));
  assign hit_out = hit_le;

  // get shifts every cell; a duplicate put closes the gap behind the match
  assign shift = ctrl.get | (ctrl.put & hit_le);
  // the item lands on the tail for a duplicate, else on the first free slot
  assign load  = ctrl.put & (ctrl.any_hit ? sel_last : sel_free);

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = ctrl.item;
    end else if (shift) begin
      slot_nxt = slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;

endmodule

// File: design/dedup_queue_move_to_tail_top.sv
// Top level of the dedup queue: a row of DEPTH cells, the item count and
// the result register. Depends on dqmt_pkg and dqmt_cell.
//
// Usage:
//   in_*  channel: one word per command (put item_in, or get the head).
//   out_* channel: exactly one result word per command, in order, with
//   status, the removed item (zero unless a get succeeds), the empty flag
//   and the count after the command.
//   A duplicate put moves the matching entry to the tail; a new item on a
//   full queue fails with ST_FULL and leaves the queue unchanged.
// Timing:
//   The result word is registered. Throughput is one command per cycle
//   with out_ready high: all cells compare against the item at once and
//   shift together in the cycle of acceptance; the result register frees
//   in the cycle it is taken, so commands flow back to back.
// Reset and stall:
//   Reset empties the queue and drops any pending result; slot contents
//   are not cleared. While out_ready is low with a result pending,
//   in_ready is low and the queue holds its state.
module dedup_queue_move_to_tail_top
  import dqmt_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_t          out_r;
  out_t          out_nxt;

  cell_ctrl_t    ctrl;
  logic          accept;
  logic          any_hit;
  logic          full;
  logic [DEPTH:0]  hit_chain;
  logic [31:0]     slot_val [DEPTH+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign any_hit  = hit_chain[DEPTH];

  // broadcast to the cells
  assign ctrl.en      = accept && !(in_data.cmd == CMD_PUT && !any_hit && full)
                               && !(in_data.cmd == CMD_GET && count_r == '0);
  assign ctrl.put     = (in_data.cmd == CMD_PUT);
  assign ctrl.get     = (in_data.cmd == CMD_GET);
  assign ctrl.any_hit = any_hit;
  assign ctrl.item    = in_data.item_in;

  assign hit_chain[0]    = 1'b0;
  assign slot_val[DEPTH] = '0;

  // cell row, slot 0 is the head
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    dqmt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (count_r > CW'(k)),
      .sel_last  (count_r == CW'(k + 1)),
      .sel_free  (count_r == CW'(k)),
      .slot_next (slot_val[k+1]),
      .hit_in    (hit_chain[k]),
      .hit_out   (hit_chain[k+1]),
      .slot_out  (slot_val[k])
    );
  end

  // count and result word
  always_comb begin
    count_nxt  = count_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt   = 1'b1;
      out_nxt.status  = ST_OK;
      out_nxt.item_out = '0;
      if (ctrl.put) begin
        if (!any_hit) begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end else begin
        if (count_r == '0) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.item_out = slot_val[0];
          count_nxt = count_r - 1'b1;
        end
      end
      out_nxt.is_empty   = (count_nxt == '0);
      out_nxt.fill_count = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/sv/dedup_queue_move_to_tail_top_test.sv
// Self-checking testbench for dedup_queue_move_to_tail_top: a queued driver,
// a monitor and a queue-based predictor that tracks the held items.
// Depends on dqmt_pkg and the design files.
`timescale 1ns / 100ps

module dedup_queue_move_to_tail_top_test;
  import dqmt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RAND_ITEMS  = 800;
  localparam int PHASES      = 3;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // a word waiting to be sent, with its idling phase
  typedef struct {
    in_t word;
    int  phase;
    bit  drain;  // wait for every result before sending
  } pending_word_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pending_word_t pending_words[$];
  out_t          expected_results[$];
  logic [31:0]   held_items[$];
  logic [31:0]   item_pool[POOL_SIZE];
  int            cur_phase = 0;
  int            mismatches = 0;
  int            cycle_count = 0;

  dedup_queue_move_to_tail_top #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // percent of cycles each side idles, per phase
  function automatic int send_idle_pct(int ph);
    case (ph)
      0: return 33;
      1: return 64;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(int ph);
    case (ph)
      0: return 64;
      1: return 33;
      default: return 0;
    endcase
  endfunction

  // model of the queue: apply one command, return its result word
  function automatic out_t queue_step(in_t w);
    out_t res;
    int   pos;
    res = '0;
    res.status = ST_OK;
    pos = -1;
    if (w.cmd == CMD_PUT) begin
      foreach (held_items[k]) begin
        if (pos < 0 && held_items[k] == w.item_in) pos = k;
      end
      if (pos >= 0) begin
        // matching entry moves to the tail with the new value
        held_items.delete(pos);
        held_items.push_back(w.item_in);
      end else if (held_items.size() < DEPTH) begin
        held_items.push_back(w.item_in);
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (held_items.size() == 0) res.status = ST_EMPTY;
      else res.item_out = held_items.pop_front();
    end
    res.is_empty   = (held_items.size() == 0);
    res.fill_count = 5'(held_items.size());
    return res;
  endfunction

  function automatic void add_word(logic cmd, logic [31:0] item, int ph, bit drain);
    pending_word_t p;
    p.word.cmd     = cmd;
    p.word.item_in = item;
    p.phase        = ph;
    p.drain        = drain;
    pending_words.push_back(p);
  endfunction

  // driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin : drive_words
    bit launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(queue_step(in_data));
      if (!in_valid || in_ready) begin
        launch = (pending_words.size() != 0);
        if (launch && pending_words[0].drain && expected_results.size() != 0) launch = 0;
        if (launch && $urandom_range(0, 99) < send_idle_pct(pending_words[0].phase))
          launch = 0;
        if (launch) begin
          in_data   <= pending_words[0].word;
          in_valid  <= 1'b1;
          cur_phase <= pending_words[0].phase;
          void'(pending_words.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: status=%0d item=%h empty=%0d count=%0d",
                     out_data.status, out_data.item_out, out_data.is_empty,
                     out_data.fill_count);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.item_out !== want.item_out ||
              out_data.is_empty !== want.is_empty ||
              out_data.fill_count !== want.fill_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("mismatch: exp status=%0d item=%h empty=%0d count=%0d, ",
                     want.status, want.item_out, want.is_empty, want.fill_count);
              $display("got status=%0d item=%h empty=%0d count=%0d",
                       out_data.status, out_data.item_out, out_data.is_empty,
                       out_data.fill_count);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin : run_test
    int put_pct;
    logic cmd;
    logic [31:0] item;
    // directed: empty get, extremes, moves of head and tail duplicates
    add_word(CMD_GET, 32'h0, 0, 0);
    add_word(CMD_PUT, 32'h0000_0000, 0, 0);
    add_word(CMD_PUT, 32'hFFFF_FFFF, 0, 0);
    add_word(CMD_PUT, 32'h0000_0000, 0, 0);  // head duplicate goes to tail
    add_word(CMD_PUT, 32'h0000_0000, 0, 0);  // tail duplicate stays
    add_word(CMD_GET, 32'hFFFF_FFFF, 0, 0);
    add_word(CMD_GET, 32'h0, 0, 0);
    add_word(CMD_GET, 32'h0, 0, 0);
    // fill up, then a new item on full and a duplicate on full
    for (int k = 0; k < DEPTH; k++)
      add_word(CMD_PUT, (32'h1 << (2 * k)) ^ (32'hA5A5_0000 | 32'(k)), 0, 0);
    add_word(CMD_PUT, 32'h5A5A_5A5A, 0, 0);
    add_word(CMD_PUT, 32'h1 ^ 32'hA5A5_0000, 0, 0);
    add_word(CMD_GET, 32'h0, 0, 0);

    foreach (item_pool[k]) item_pool[k] = $urandom;
    put_pct = 55;
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        // bursts that lean to puts or to gets, to reach full and empty
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: put_pct = 30;
            1: put_pct = 55;
            default: put_pct = 80;
          endcase
        end
        cmd  = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_GET;
        item = ($urandom_range(0, 9) < 7) ? item_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        add_word(cmd, item, ph, n == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
